/* rtl/core/utf8d_pkg.sv */
// Shared types, constants and lookup function for the UTF-8 decoder.
package utf8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned StW     = 4;
  localparam int unsigned ClsW    = 4;
  localparam int unsigned NumSt   = 9;
  localparam int unsigned NumCls  = 16;

  localparam logic [StW-1:0] StAccept = 4'd0;
  localparam logic [StW-1:0] StReject = 4'd1;
  localparam logic [StW-1:0] StLast   = 4'd8;

  typedef enum logic [1:0] {
    StatComplete = 2'd0,
    StatPending  = 2'd1,
    StatInvalid  = 2'd2
  } status_e;

  // Automaton state carried from one byte to the next.
  typedef struct packed {
    logic [StW-1:0] st;
    logic [CpW-1:0] accum;
  } dec_state_t;

  // Next state indexed by [state][class].
  localparam logic [StW-1:0] NextStTbl [NumSt][NumCls] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
    '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
  };

  // Character class of a raw byte.
  function automatic logic [ClsW-1:0] byte_class(input logic [ByteW-1:0] b);
    logic [ClsW-1:0] cls;
    if (b < 8'h80)       cls = 4'd0;
    else if (b < 8'h90)  cls = 4'd1;
    else if (b < 8'hA0)  cls = 4'd9;
    else if (b < 8'hC0)  cls = 4'd7;
    else if (b < 8'hC2)  cls = 4'd8;
    else if (b < 8'hE0)  cls = 4'd2;
    else if (b == 8'hE0) cls = 4'd10;
    else if (b == 8'hED) cls = 4'd4;
    else if (b < 8'hF0)  cls = 4'd3;
    else if (b == 8'hF0) cls = 4'd11;
    else if (b < 8'hF4)  cls = 4'd6;
    else if (b == 8'hF4) cls = 4'd5;
    else                 cls = 4'd8;
    return cls;
  endfunction

endpackage

/* rtl/core/utf8d_if.sv */
// Valid/ready channel interfaces for the UTF-8 decoder byte and result streams.
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface

/* rtl/core/utf8_dfa_decoder.sv */
// Top level of the validating UTF-8 decoder: input register, automaton step, result register.
//
//   channel | port  | dir | payload
//   --------+-------+-----+-------------------------------------------
//   bytes   | in_i  | in  | in_byte[7:0]
//   results | out_o | out | code_point[20:0], status[1:0]
//
// One byte per clock while results are taken; a byte goes into the byte register when
//   it is taken, and its result goes into the result register when that byte advances.
// The automaton state update and table lookup sit between the two registers.
// Reset clears both valid flags and returns the automaton to the accept state.
// A stalled result holds; the input register still takes a byte, and only
//   stops when both stages are full and the result is not taken.
module utf8_dfa_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);
  import utf8d_pkg::*;

  // Input stage
  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;

  // Automaton state
  dec_state_t       state_q;
  dec_state_t       state_d;

  // Result stage
  logic             out_valid_q;
  logic [CpW-1:0]   cp_q;
  logic [CpW-1:0]   cp_d;
  logic [1:0]       status_q;
  logic [1:0]       status_d;

  logic             advance;
  logic             in_take;

  // Move the held byte into the result stage when that stage is free or draining.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  utf8d_step u_step (
    .byte_i       (byte_q),
    .cur_i        (state_q),
    .nxt_o        (state_d),
    .code_point_o (cp_d),
    .status_o     (status_d)
  );

  // Control: valid flags and automaton state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.st    <= StAccept;
      state_q.accum <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_i.in_byte;
    end
    if (advance) begin
      cp_q     <= cp_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = cp_q;
  assign out_o.status     = status_q;

  // Reject is sticky until reset.
  a_reject_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.st == StReject |=> state_q.st == StReject)
    else $error("reject state left without reset");

  // Only states 0..8 are ever reached.
  a_state_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.st <= StLast)
    else $error("automaton state out of range");

  // Incomplete results carry a zero code point.
  a_cp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StatComplete |-> cp_q == '0)
    else $error("code point shown on incomplete result");

  // A byte moved on always leaves a result pending.
  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

endmodule

/* rtl/core/utf8d_step.sv */
// One automaton step: classify the byte, update state and accumulator, form the result.
module utf8d_step (
  input  logic [7:0]            byte_i,
  input  utf8d_pkg::dec_state_t cur_i,
  output utf8d_pkg::dec_state_t nxt_o,
  output logic [20:0]           code_point_o,
  output logic [1:0]            status_o
);
  import utf8d_pkg::*;

  logic [ClsW-1:0]  cls;
  logic [StW-1:0]   st;
  logic [ByteW-1:0] lead_bits;

  always_comb begin
    cls = byte_class(byte_i);
    // Fold any out-of-range state into reject.
    st = (cur_i.st > StLast) ? StReject : cur_i.st;
    lead_bits = (8'hFF >> cls) & byte_i;

    if (st != StAccept) begin
      nxt_o.accum = {cur_i.accum[CpW-7:0], byte_i[5:0]};
    end else begin
      nxt_o.accum = {{(CpW-ByteW){1'b0}}, lead_bits};
    end
    nxt_o.st = NextStTbl[st][cls];

    if (nxt_o.st == StAccept) begin
      code_point_o = nxt_o.accum;
      status_o     = StatComplete;
    end else if (nxt_o.st == StReject) begin
      code_point_o = '0;
      status_o     = StatInvalid;
    end else begin
      code_point_o = '0;
      status_o     = StatPending;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the UTF-8 decoder: byte stream in, code points and status out.
module tb;
  import utf8d_pkg::*;

  // Character classes of a raw byte, as the automaton sees them.
  localparam logic [3:0] ClsAscii  = 4'd0;   // 00..7F
  localparam logic [3:0] ClsCont8x = 4'd1;   // 80..8F
  localparam logic [3:0] ClsLead2  = 4'd2;   // C2..DF
  localparam logic [3:0] ClsLead3  = 4'd3;   // E1..EC, EE..EF
  localparam logic [3:0] ClsLeadED = 4'd4;
  localparam logic [3:0] ClsLeadF4 = 4'd5;
  localparam logic [3:0] ClsLead4  = 4'd6;   // F1..F3
  localparam logic [3:0] ClsContAx = 4'd7;   // A0..BF
  localparam logic [3:0] ClsNever  = 4'd8;   // C0, C1, F5..FF
  localparam logic [3:0] ClsCont9x = 4'd9;   // 90..9F
  localparam logic [3:0] ClsLeadE0 = 4'd10;
  localparam logic [3:0] ClsLeadF0 = 4'd11;

  // Automaton states beyond accept and reject.
  localparam logic [StW-1:0] StOneMore = 4'd2;  // one continuation byte to go
  localparam logic [StW-1:0] StTwoMore = 4'd3;  // two to go
  localparam logic [StW-1:0] StAfterE0 = 4'd4;  // next byte must be A0..BF
  localparam logic [StW-1:0] StAfterED = 4'd5;  // next byte must be 80..9F
  localparam logic [StW-1:0] StAfterF0 = 4'd6;  // next byte must be 90..BF
  localparam logic [StW-1:0] StAfterF1 = 4'd7;  // any continuation, three to go
  localparam logic [StW-1:0] StAfterF4 = 4'd8;  // next byte must be 80..8F

  // Kinds of broken sequence used once, at the tail of the run.
  typedef enum int {
    BrkOverlong,
    BrkSurrogate,
    BrkTooHigh,
    BrkMissingCont,
    BrkStrayCont
  } broken_kind_e;

  localparam int unsigned IdlePct   = 28;
  localparam int unsigned StallLim  = 1000;
  localparam int unsigned RandBytes = 420;
  localparam int unsigned NoiseLen  = 25;
  localparam int unsigned DrainCyc  = 8;

  // Boundary code points, picked now and then in the random stream.
  localparam logic [CpW-1:0] CpBounds [10] = '{
    21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800,
    21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF
  };

  typedef struct {
    logic [CpW-1:0] cp;
    status_e        stat;
  } cp_result_t;

  // Tracks the decoder's automaton and holds the results still awaited.
  class code_point_checker;
    logic [StW-1:0] dfa_st;
    logic [CpW-1:0] accum;
    cp_result_t     awaited[$];
    int unsigned    mismatches;

    function new();
      dfa_st     = StAccept;
      accum      = '0;
      mismatches = 0;
    endfunction

    static function logic [3:0] char_class(logic [7:0] b);
      logic [3:0] cls;
      if (!b[7]) begin
        cls = ClsAscii;
      end else begin
        case (b[6:4])
          3'd0:    cls = ClsCont8x;
          3'd1:    cls = ClsCont9x;
          3'd2,
          3'd3:    cls = ClsContAx;
          3'd4:    cls = (b[3:1] == 3'b000) ? ClsNever : ClsLead2;
          3'd5:    cls = ClsLead2;
          3'd6:    cls = (b == 8'hE0) ? ClsLeadE0 : (b == 8'hED) ? ClsLeadED : ClsLead3;
          default: cls = (b == 8'hF0) ? ClsLeadF0 : (b < 8'hF4) ? ClsLead4 :
                         (b == 8'hF4) ? ClsLeadF4 : ClsNever;
        endcase
      end
      return cls;
    endfunction

    static function logic [StW-1:0] next_dfa(logic [StW-1:0] st, logic [3:0] cls);
      logic            any_cont;
      logic [StW-1:0]  nx;
      any_cont = (cls == ClsCont8x) || (cls == ClsCont9x) || (cls == ClsContAx);
      nx = StReject;
      case (st)
        StAccept: begin
          case (cls)
            ClsAscii:  nx = StAccept;
            ClsLead2:  nx = StOneMore;
            ClsLead3:  nx = StTwoMore;
            ClsLeadE0: nx = StAfterE0;
            ClsLeadED: nx = StAfterED;
            ClsLeadF0: nx = StAfterF0;
            ClsLead4:  nx = StAfterF1;
            ClsLeadF4: nx = StAfterF4;
            default:   nx = StReject;
          endcase
        end
        StOneMore: if (any_cont) nx = StAccept;
        StTwoMore: if (any_cont) nx = StOneMore;
        StAfterE0: if (cls == ClsContAx) nx = StOneMore;
        StAfterED: if (cls == ClsCont8x || cls == ClsCont9x) nx = StOneMore;
        StAfterF0: if (cls == ClsCont9x || cls == ClsContAx) nx = StTwoMore;
        StAfterF1: if (any_cont) nx = StTwoMore;
        StAfterF4: if (cls == ClsCont8x) nx = StTwoMore;
        default:   nx = StReject;
      endcase
      return nx;
    endfunction

    // Advance the automaton by one accepted byte and queue its result.
    function void take_byte(logic [7:0] b);
      logic [3:0]     cls;
      logic [StW-1:0] st;
      cp_result_t     res;
      cls = char_class(b);
      st  = (dfa_st > StLast) ? StReject : dfa_st;
      if (st != StAccept) accum = {accum[CpW-7:0], b[5:0]};
      else                accum = CpW'(b & (8'hFF >> cls));
      st     = next_dfa(st, cls);
      dfa_st = st;
      if (st == StAccept) begin
        res.cp   = accum;
        res.stat = StatComplete;
      end else if (st == StReject) begin
        res.cp   = '0;
        res.stat = StatInvalid;
      end else begin
        res.cp   = '0;
        res.stat = StatPending;
      end
      awaited.push_back(res);
    endfunction

    function void check_cp(logic [CpW-1:0] cp, logic [1:0] stat);
      cp_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result cp=%h status=%0d", cp, stat);
        return;
      end
      want = awaited.pop_front();
      if (cp !== want.cp || stat !== want.stat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch: expected cp=%h status=%0d, got cp=%h status=%0d",
                   want.cp, want.stat, cp, stat);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  utf8d_in_if  bytes_if ();
  utf8d_out_if cps_if ();

  utf8_dfa_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bytes_if.sink),
    .out_o  (cps_if.source)
  );

  code_point_checker cps_chk = new();

  bit          calm;         // suppress idling on both sides
  int unsigned bytes_sent;
  int unsigned quiet_cyc;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Send one request on the byte channel, idling first at random.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IdlePct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bytes_if.valid   <= 1'b1;
    bytes_if.in_byte <= b;
    do @(posedge clk_i); while (!(bytes_if.valid && bytes_if.ready));
    bytes_sent++;
  endtask

  // Sample both channels at the clock edge; the prediction is queued before any
  // result is checked, so even a result shown in the same cycle as its byte would find it waiting.
  // Drive the result channel's ready at random and watch for a hang.
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni && bytes_if.valid && bytes_if.ready) begin
      cps_chk.take_byte(bytes_if.in_byte);
      moved = 1'b1;
    end
    if (rst_ni && cps_if.valid && cps_if.ready) begin
      cps_chk.check_cp(cps_if.code_point, cps_if.status);
      moved = 1'b1;
    end
    cps_if.ready <= calm || ($urandom_range(99) >= IdlePct);
    if (!rst_ni || moved) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
      if (quiet_cyc >= StallLim) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned    len;
    broken_kind_e   kind;
    logic [CpW-1:0] cp;
    logic [7:0]     six;

    calm       = 1'b0;
    bytes_sent = 0;
    rst_ni           <= 1'b0;
    bytes_if.valid   <= 1'b0;
    bytes_if.in_byte <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ASCII extremes, then the smallest of each length, the largest of two bytes,
    // the top of the range below the surrogates, and the last valid code point.
    // Every lead byte with a narrowed second byte appears here.
    send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'hC2); send_byte(8'h80);
    send_byte(8'hDF); send_byte(8'hBF);
    send_byte(8'hE0); send_byte(8'hA0); send_byte(8'h80);
    send_byte(8'hED); send_byte(8'h9F); send_byte(8'hBF);
    send_byte(8'hF0); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hF3); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);

    // Random well-formed text. Rejection is sticky until reset, so keep the
    // stream valid here; a middle stretch runs with no idling at all.
    while (bytes_sent < RandBytes) begin
      calm = (bytes_sent >= 150) && (bytes_sent < 250);
      len  = $urandom_range(4, 1);
      case (len)
        1:       cp = CpW'($urandom_range(8'h7F));
        2:       cp = CpW'($urandom_range(11'h7FF, 8'h80));
        3:       cp = CpW'($urandom_range(16'hFFFF, 12'h800));
        default: cp = CpW'($urandom_range(21'h10FFFF, 17'h10000));
      endcase
      if ($urandom_range(9) == 0) cp = CpBounds[$urandom_range(9)];
      // steer clear of the surrogate block
      if (cp[20:11] == 10'b0000011011) cp[15] = 1'b0;
      if (cp < 21'h80) begin
        send_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        send_byte({3'b110, cp[10:6]});
        send_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        send_byte({4'b1110, cp[15:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end else begin
        send_byte({5'b11110, cp[20:18]});
        send_byte({2'b10, cp[17:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
    end
    calm = 1'b0;

    // One broken sequence, of a kind the seed picks, then noise: everything
    // after it must stay invalid.
    kind = broken_kind_e'($urandom_range(BrkStrayCont, BrkOverlong));
    six  = 8'h80 | 8'($urandom_range(6'h3F));
    case (kind)
      BrkOverlong: begin
        case ($urandom_range(2))
          0: begin send_byte(8'hC0 | 8'($urandom_range(1))); send_byte(six); end
          1: begin send_byte(8'hE0); send_byte(8'h80 | 8'($urandom_range(5'h1F))); end
          default: begin send_byte(8'hF0); send_byte(8'h80 | 8'($urandom_range(4'hF))); end
        endcase
      end
      BrkSurrogate: begin
        send_byte(8'hED);
        send_byte(8'hA0 | 8'($urandom_range(5'h1F)));
        send_byte(six);
      end
      BrkTooHigh: begin
        if ($urandom_range(1)) begin
          send_byte(8'hF4);
          send_byte(8'($urandom_range(8'hBF, 8'h90)));
        end else begin
          send_byte(8'($urandom_range(8'hFF, 8'hF5)));
        end
      end
      BrkMissingCont: begin
        send_byte(8'hE1);
        send_byte(six);
        send_byte(8'($urandom_range(8'h7F)));
      end
      default: send_byte(six);
    endcase
    repeat (NoiseLen) send_byte(8'($urandom_range(8'hFF)));
    bytes_if.valid <= 1'b0;

    // Drain: let the last request reach the checker, wait for every awaited
    // result, then keep watching for stray results.
    @(posedge clk_i);
    while (cps_chk.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (cps_chk.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
